// File: rtl/comb_allpass_reverb_unit_assert.svh
// Assertion macros shared by the reverb RTL.
// Needs nothing else; define ASSERT_OFF to compile the checks away.
`ifndef COMB_ALLPASS_REVERB_UNIT_ASSERT_SVH
`define COMB_ALLPASS_REVERB_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define CARV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("reverb: same-cycle check failed");
`define CARV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("reverb: next-cycle check failed");
`define CARV_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("reverb: forbidden condition seen");
`else
`define CARV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CARV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define CARV_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/carv_pkg.sv
// Shared widths, reset values, register codes and helpers of the reverb block.
// Used by the multiplier, the top level and the testbench.
package carv_pkg;
	localparam int DATA_W    = 16;
	localparam int COEF_W    = 15;
	localparam int DELAY_W   = 11;
	localparam int GAIN_W    = 15;
	localparam int PROD_W    = 17;
	localparam int SUM_W     = 19;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 15;
	localparam int DEPTH_DEF = 2048;

	localparam logic [DELAY_W-1:0] DELAY_RST  = 11'd1499;
	localparam logic [GAIN_W-1:0]  GAIN_RST   = 15'd8192;
	localparam logic               ENABLE_RST = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DELAY  = 2'd0,
		CFG_GAIN   = 2'd1,
		CFG_ENABLE = 2'd2
	} cfg_idx_t;

	// One request to the shared multiplier.
	typedef struct packed {
		logic                     en;
		logic signed [DATA_W-1:0] a;
		logic [COEF_W-1:0]        c;
	} mul_req_t;

	function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > SUM_W'(32767))
			r = 16'sh7FFF;
		else if (v < -SUM_W'(32768))
			r = -16'sh8000;
		else
			r = v[DATA_W-1:0];
		return r;
	endfunction
endpackage

// File: rtl/carv_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stands alone; no package needed.
module carv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// File: rtl/carv_mul.sv
// Shared Q1.15 by Q0.15 multiplier with round-half-up and a registered product.
// Depends on carv_pkg for widths and the request struct.
module carv_mul
	import carv_pkg::*;
(
	input  logic                     clk,
	input  mul_req_t                 req,
	output logic signed [PROD_W-1:0] prod_q
);
	logic signed [31:0] full;

	// The coefficient is unsigned, so it enters the signed product with a zero on top.
	assign full = req.a * $signed({1'b0, req.c}) + 32'sd16384;

	always_ff @(posedge clk) begin
		if (req.en)
			prod_q <= full[31:15];
	end
endmodule

// File: rtl/comb_allpass_reverb_unit.sv
// Top level of the comb plus allpass reverb: sequencer, registers and three delay RAMs.
// Depends on carv_pkg, carv_ram, carv_mul and the assertion header.
//
// Channel | Direction | Handshake             | Payload
// in      | into      | in_valid / in_stall   | sample_in, feedback_coef
// out     | out of    | out_valid / out_stall | sample_out
// cfg     | into      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each item steps through S_ADDR, S_MULH, S_COMB, S_MULC, S_SUM, S_MULG and S_OUT before the
// next input transfer is possible; with reverb disabled S_MULH, S_COMB and S_MULC are skipped.
// The single shared multiplier is used three times in sequence (once when disabled).
// After reset a clearing pass zeroes every address of the three RAMs with in_stall high.
// A delay write of DEPTH or more is reduced by one subtraction of DEPTH per cycle while no config
// write is accepted, with in_stall high meanwhile. A result waits in the output register while
// out_stall is high; the sequencer holds in its last step until that register frees.
`include "comb_allpass_reverb_unit_assert.svh"
module comb_allpass_reverb_unit
	import carv_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [DATA_W-1:0]    sample_in,
	input  logic [COEF_W-1:0]           feedback_coef,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [DATA_W-1:0]    sample_out,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DAT_W-1:0]        cfg_data
);
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE, S_ADDR, S_MULH, S_COMB, S_MULC, S_SUM, S_MULG, S_OUT
	} state_t;

	state_t                     state_q;
	logic [AW-1:0]              w_q;
	logic [AW-1:0]              clr_cnt_q;
	logic                       clr_busy_q;
	logic [DELAY_W-1:0]         dm_q;
	logic [GAIN_W-1:0]          gain_q;
	logic                       en_q;
	logic signed [DATA_W-1:0]   x_q;
	logic [COEF_W-1:0]          g_q;
	logic                       rw_eq_q;
	logic signed [PROD_W-1:0]   gh_q;
	logic signed [DATA_W-1:0]   comb_q;
	logic signed [DATA_W-1:0]   y_q;
	logic                       out_valid_q;
	logic signed [DATA_W-1:0]   sample_out_q;

	logic                       dm_big;
	logic                       in_acc;
	logic                       cfg_acc;
	logic                       out_load;
	logic [AW-1:0]              w_next;
	logic [AW:0]                dm_w;
	logic [AW:0]                diff;
	logic [AW-1:0]              r_addr;
	logic signed [DATA_W-1:0]   comb;
	logic signed [DATA_W-1:0]   a_sel;
	logic signed [DATA_W-1:0]   y;
	logic signed [PROD_W-1:0]   prod_q;
	mul_req_t                   mreq;

	logic                       dl_we, ah_we, oh_we;
	logic [AW-1:0]              dl_wa, ah_wa, oh_wa;
	logic [DATA_W-1:0]          dl_wd, ah_wd, oh_wd;
	logic                       rd_en;
	logic [DATA_W-1:0]          dl_rd, ah_rd, oh_rd;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign dm_big    = 32'(dm_q) >= 32'(DEPTH);
	assign in_stall  = (state_q != S_IDLE) || clr_busy_q || dm_big;
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// Index arithmetic; dm_q is below DEPTH whenever an item is accepted.
	assign w_next = (w_q == AW'(DEPTH - 1)) ? '0 : w_q + AW'(1);
	assign dm_w   = (AW+1)'(dm_q);
	assign diff   = {1'b0, w_q} - dm_w;
	assign r_addr = diff[AW] ? AW'(diff + (AW+1)'(DEPTH)) : diff[AW-1:0];

	assign comb  = sat16(SUM_W'($signed(dl_rd)) + SUM_W'(prod_q));
	// When the read index meets the write index, the allpass tap sees the fresh comb.
	assign a_sel = rw_eq_q ? comb_q : $signed(ah_rd);
	assign y     = en_q ? sat16(SUM_W'(a_sel) - SUM_W'(prod_q) + SUM_W'(gh_q)) : x_q;

	always_comb begin
		mreq = '{en: 1'b0, a: $signed(oh_rd), c: g_q};
		case (state_q)
			S_MULH: mreq = '{en: 1'b1, a: $signed(oh_rd), c: g_q};
			S_MULC: mreq = '{en: 1'b1, a: comb_q, c: g_q};
			S_MULG: mreq = '{en: 1'b1, a: y_q, c: gain_q};
			default: ;
		endcase
	end

	always_comb begin
		dl_we = clr_busy_q || in_acc;
		dl_wa = clr_busy_q ? clr_cnt_q : w_q;
		dl_wd = clr_busy_q ? '0 : sample_in;
		ah_we = clr_busy_q || (state_q == S_COMB);
		ah_wa = clr_busy_q ? clr_cnt_q : w_q;
		ah_wd = clr_busy_q ? '0 : comb;
		oh_we = clr_busy_q || (state_q == S_SUM);
		oh_wa = clr_busy_q ? clr_cnt_q : w_q;
		oh_wd = clr_busy_q ? '0 : y;
		rd_en = (state_q == S_ADDR);
	end

	carv_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_delay_ram (
		.clk(clk), .we(dl_we), .waddr(dl_wa), .wdata(dl_wd),
		.re(rd_en), .raddr(r_addr), .rdata(dl_rd)
	);

	carv_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_allpass_ram (
		.clk(clk), .we(ah_we), .waddr(ah_wa), .wdata(ah_wd),
		.re(rd_en), .raddr(r_addr), .rdata(ah_rd)
	);

	carv_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_history_ram (
		.clk(clk), .we(oh_we), .waddr(oh_wa), .wdata(oh_wd),
		.re(rd_en), .raddr(r_addr), .rdata(oh_rd)
	);

	carv_mul u_mul (
		.clk(clk), .req(mreq), .prod_q(prod_q)
	);

	// Configuration registers and delay reduction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dm_q   <= DELAY_RST;
			gain_q <= GAIN_RST;
			en_q   <= ENABLE_RST;
		end else if (cfg_acc) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DELAY:  dm_q   <= cfg_data[DELAY_W-1:0];
				CFG_GAIN:   gain_q <= cfg_data[GAIN_W-1:0];
				CFG_ENABLE: en_q   <= cfg_data[0];
				default: ;
			endcase
		end else if (dm_big) begin
			dm_q <= dm_q - DELAY_W'(DEPTH);
		end
	end

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == AW'(DEPTH - 1))
				clr_busy_q <= 1'b0;
		end
	end

	// Sequencer with its registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			w_q          <= '0;
			out_valid_q  <= 1'b0;
			sample_out_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q  <= 1'b1;
				sample_out_q <= sat16(SUM_W'(prod_q));
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						w_q     <= w_next;
						state_q <= S_ADDR;
					end
				end
				S_ADDR:  state_q <= en_q ? S_MULH : S_SUM;
				S_MULH:  state_q <= S_COMB;
				S_COMB:  state_q <= S_MULC;
				S_MULC:  state_q <= S_SUM;
				S_SUM:   state_q <= S_MULG;
				S_MULG:  state_q <= S_OUT;
				S_OUT: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= sample_in;
			g_q <= feedback_coef;
		end
		if (state_q == S_ADDR)
			rw_eq_q <= (r_addr == w_q);
		if (state_q == S_COMB) begin
			gh_q   <= prod_q;
			comb_q <= comb;
		end
		if (state_q == S_SUM)
			y_q <= y;
	end

	`CARV_ASSERT_IMP(a_acc_ready, clk, arst_n, in_acc, !clr_busy_q && 32'(dm_q) < 32'(DEPTH))
	`CARV_ASSERT_NEXT(a_acc_addr, clk, arst_n, in_acc, state_q == S_ADDR)
	`CARV_ASSERT_IMP(a_clr_idle, clk, arst_n, clr_busy_q, state_q == S_IDLE)
	`CARV_ASSERT_NEVER(a_out_overrun, clk, arst_n, out_load && out_valid_q && out_stall)
endmodule

// File: tb/sv/comb_allpass_reverb_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the comb plus allpass reverb unit.
// Predicts every output sample from its own copy of the three delay lines and the registers.
// Depends on carv_pkg and the comb_allpass_reverb_unit RTL.
module comb_allpass_reverb_unit_tb
	import carv_pkg::*;
;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int RUN_LIMIT_NS = 2_000_000;
	localparam int MAX_PRINTED = 40;
	localparam int COEF_LO = 9830;   // 0.3 in Q0.15
	localparam int COEF_HI = 18022;  // 0.55 in Q0.15

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [DATA_W-1:0] sample_in;
	logic [COEF_W-1:0]        feedback_coef;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] sample_out;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DAT_W-1:0]     cfg_data;

	// Predicted state of the block.
	logic signed [DATA_W-1:0] dly_mem  [0:DEPTH_DEF-1];
	logic signed [DATA_W-1:0] hist_mem [0:DEPTH_DEF-1];
	logic signed [DATA_W-1:0] ap_mem   [0:DEPTH_DEF-1];
	logic [DELAY_W-1:0]       wr_ptr;
	logic [DELAY_W-1:0]       reg_delay;
	logic [GAIN_W-1:0]        reg_gain;
	logic                     reg_enable;

	logic signed [DATA_W-1:0] pending_out [$];
	logic signed [DATA_W-1:0] want_out;
	int err_count;
	int tx_gap_max;
	int rx_gap_max;
	int long_hold;

	comb_allpass_reverb_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample_in     (sample_in),
		.feedback_coef (feedback_coef),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample_out    (sample_out),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("status: fail");
		$finish;
	end

	function automatic logic signed [DATA_W-1:0] clip16(input longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return -16'sh8000;
		return v[DATA_W-1:0];
	endfunction

	// Q1.15 times Q0.15, rounded half up with floor division.
	function automatic longint scale_q15(input longint s, input longint c);
		return (s * c + 16384) >>> 15;
	endfunction

	function automatic logic signed [DATA_W-1:0] next_reverb_sample(
		input logic signed [DATA_W-1:0] s, input logic [COEF_W-1:0] g);
		logic [DELAY_W-1:0] rd;
		longint gh;
		logic signed [DATA_W-1:0] comb;
		logic signed [DATA_W-1:0] y;
		dly_mem[wr_ptr] = s;
		wr_ptr = wr_ptr + DELAY_W'(1);
		rd = wr_ptr - reg_delay;
		if (reg_enable) begin
			gh = scale_q15(hist_mem[rd], g);
			comb = clip16(longint'(dly_mem[rd]) + gh);
			// With a zero delay the allpass read below sees this fresh comb value.
			ap_mem[wr_ptr] = comb;
			y = clip16(-scale_q15(comb, g) + longint'(ap_mem[rd]) + gh);
		end else begin
			y = s;
		end
		hist_mem[wr_ptr] = y;
		return clip16(scale_q15(y, reg_gain));
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		err_count++;
		if (err_count <= MAX_PRINTED)
			$display("mismatch: %s, got %0d, want %0d", what, got, want);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_out.size() == 0) begin
				report_mismatch("output sample with none pending", sample_out, 0);
			end else begin
				want_out = pending_out.pop_front();
				if (sample_out !== want_out)
					report_mismatch("sample_out", sample_out, want_out);
			end
		end
	end

	// Output side: draws a stall count per transfer, or takes a long hold when asked.
	initial begin : drain_side
		int n;
		out_stall = 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold > 0) begin
				n = long_hold;
				long_hold = 0;
			end else begin
				n = $urandom_range(0, rx_gap_max);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Called at a falling edge; leaves in_valid high so the next sample can follow at once.
	task automatic send_sample(input logic signed [DATA_W-1:0] s, input logic [COEF_W-1:0] g);
		int n;
		n = $urandom_range(0, tx_gap_max);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= s;
		feedback_coef <= g;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_out.push_back(next_reverb_sample(s, g));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_out.size() != 0) @(negedge clk);
	endtask

	// Keeps cfg_valid high on exit when another write follows directly.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data,
		input bit more);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_DELAY:  reg_delay = data[DELAY_W-1:0];
			CFG_GAIN:   reg_gain = data[GAIN_W-1:0];
			CFG_ENABLE: reg_enable = data[0];
			default:    ;
		endcase
		@(negedge clk);
		if (!more)
			cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input logic [CFG_DAT_W-1:0] dly_data,
		input logic [CFG_DAT_W-1:0] gain_data, input logic [CFG_DAT_W-1:0] en_data);
		write_reg(CFG_DELAY, dly_data, 1'b1);
		write_reg(CFG_GAIN, gain_data, 1'b1);
		write_reg(CFG_ENABLE, en_data, 1'b0);
	endtask

	function automatic logic [COEF_W-1:0] pick_coef();
		int k;
		k = $urandom_range(0, 19);
		case (k)
			0, 1:    return COEF_W'($urandom_range(0, 32767));
			2:       return 15'h7FFF;
			3:       return 15'h0000;
			default: return COEF_W'($urandom_range(COEF_LO, COEF_HI));
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_sample(input bit quiet);
		int k;
		k = $urandom_range(0, 19);
		if (k == 0)
			return 16'sh7FFF;
		if (k == 1)
			return -16'sh8000;
		if (quiet)
			return DATA_W'(int'($urandom_range(0, 8191)) - 4096);
		return DATA_W'($urandom);
	endfunction

	task automatic test_reset_values();
		send_sample(16'sh7FFF, 15'd0);
		send_sample(-16'sh8000, 15'h7FFF);
		send_sample(16'sh0000, 15'd16384);
		send_sample(-16'sh0001, 15'(COEF_LO));
		wait_drained();
	endtask

	// Short delay and full scale coefficient so the feedback path saturates.
	task automatic test_saturation();
		set_regs(15'd1, 15'h7FFF, 15'd1);
		repeat (3) send_sample(16'sh7FFF, 15'h7FFF);
		repeat (3) send_sample(-16'sh8000, 15'h7FFF);
		send_sample(16'sh0000, 15'd0);
		send_sample(16'sh0001, 15'd1);
		wait_drained();
	endtask

	task automatic test_bypass();
		// Only bit 0 of the enable data counts.
		set_regs(15'd1, 15'd0, 15'h7FFE);
		send_sample(16'sh7FFF, 15'h7FFF);
		send_sample(-16'sh8000, 15'd0);
		wait_drained();
		write_reg(CFG_GAIN, 15'h7FFF, 1'b0);
		send_sample(-16'sh8000, 15'd12345);
		send_sample(16'sh7FFF, 15'd0);
		send_sample(-16'sh0001, 15'd1);
		wait_drained();
	endtask

	task automatic test_delay_edges();
		set_regs(15'd0, 15'h7FFF, 15'd1);
		send_sample(16'sd20000, 15'd16384);
		send_sample(-16'sd20000, 15'h7FFF);
		send_sample(16'sd5, 15'd20000);
		wait_drained();
		// Upper data bits above the delay width are dropped, leaving 2047.
		write_reg(CFG_DELAY, 15'h7FFF, 1'b0);
		send_sample(16'sd1234, 15'(COEF_HI));
		send_sample(-16'sd1234, 15'(COEF_LO));
		send_sample(16'sh7FFF, 15'h7FFF);
		wait_drained();
		write_reg(CFG_UNUSED, 15'h7FFF, 1'b0);
		send_sample(16'sd777, 15'd16384);
		wait_drained();
	endtask

	task automatic test_random_mix();
		logic [DELAY_W-1:0] dly;
		logic [CFG_DAT_W-1:0] gain;
		logic en;
		for (int ph = 0; ph < 9; ph++) begin
			wait_drained();
			tx_gap_max = (ph % 3 == 0) ? 0 : 18;
			rx_gap_max = (ph % 4 == 1) ? 0 : 18;
			case (ph)
				0:       dly = 11'd1;
				2:       dly = 11'd0;
				5:       dly = 11'd2047;
				7:       dly = DELAY_W'($urandom_range(1, 2047));
				default: dly = DELAY_W'($urandom_range(1, 48));
			endcase
			case (ph)
				3:       gain = 15'h7FFF;
				6:       gain = 15'd0;
				default: gain = CFG_DAT_W'($urandom_range(0, 32767));
			endcase
			en = (ph != 4);
			set_regs({4'($urandom_range(0, 15)), dly}, gain,
				{14'($urandom_range(0, 16383)), en});
			repeat (150) send_sample(pick_sample(ph % 2 == 0), pick_coef());
		end
		wait_drained();
	endtask

	// A long output hold fills the block until it stalls its input.
	task automatic test_backpressure();
		set_regs(15'd7, 15'd20000, 15'd1);
		tx_gap_max = 0;
		rx_gap_max = 18;
		long_hold = 300;
		repeat (40) send_sample(pick_sample(1'b0), pick_coef());
		wait_drained();
		long_hold = 200;
		repeat (30) send_sample(pick_sample(1'b1), pick_coef());
		wait_drained();
		tx_gap_max = 18;
		repeat (30) send_sample(pick_sample(1'b0), pick_coef());
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_in = '0;
		feedback_coef = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DELAY;
		cfg_data = '0;
		err_count = 0;
		long_hold = 0;
		tx_gap_max = 18;
		rx_gap_max = 18;
		for (int i = 0; i < DEPTH_DEF; i++) begin
			dly_mem[i] = '0;
			hist_mem[i] = '0;
			ap_mem[i] = '0;
		end
		wr_ptr = '0;
		reg_delay = DELAY_RST;
		reg_gain = GAIN_RST;
		reg_enable = ENABLE_RST;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_values();
		test_saturation();
		test_bypass();
		test_delay_edges();
		test_random_mix();
		test_backpressure();

		wait_drained();
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
